### hdl/abfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abfb_pkg
// Shared types, command codes and pixel arithmetic for the additive blend
// frame buffer.
// ----------------------------------------------------------------------------
package abfb_pkg;

  // default store geometry
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // field widths
  localparam int COORD_W = 7;
  localparam int CHAN_W  = 8;
  localparam int INTEN_W = 10;
  localparam int OPND_W  = 10;  // scaled blend channel reaches 1019
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // command codes
  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_BLEND = 3'd2;
  localparam logic [2:0] CMD_FILL  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // register index, taken from paddr bit 2
  localparam logic REG_PANEL_WIDTH  = 1'b0;
  localparam logic REG_PANEL_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] PANEL_RESET = 7'd64;
  localparam logic [CHAN_W-1:0]  CHAN_FULL   = 8'hFF;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // (c * k + 128) >> 8, rounds half up; result fits in 10 bits
  function automatic logic [OPND_W-1:0] scale(input logic [CHAN_W-1:0] c,
                                              input logic [INTEN_W-1:0] k);
    logic [18:0] prod;
    prod = 19'(c) * 19'(k) + 19'd128;
    return prod[17:8];
  endfunction

  // saturating channel add
  function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                input logic [OPND_W-1:0] b);
    logic [OPND_W:0] sum;
    sum = {3'b000, a} + {1'b0, b};
    return (sum > 11'(CHAN_FULL)) ? CHAN_FULL : sum[CHAN_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/additive_blend_frame_buffer_unit.sv
// Set, add, blend and read: one item per cycle unless the result stalls;
// memory read at the accepting edge, modify/write and result registered once
// the result register is free. Fill rectangle: its area is then written by a
// single-port write walker; no item is taken during the walk.
// After reset a clearing pass writes zero to all 2**(XW+YW) entries, one a
// cycle (4096 at default size); items wait, configuration writes are taken.
`default_nettype none
// ----------------------------------------------------------------------------
// additive_blend_frame_buffer_unit
// RGB frame buffer with set, saturating add, scaled blend, rectangle fill and
// read commands, held in one synchronous memory with read-modify-write.
// ----------------------------------------------------------------------------
module additive_blend_frame_buffer_unit #(
  parameter int MAX_WIDTH  = abfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = abfb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [abfb_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [abfb_pkg::PDATA_W-1:0]  pwdata,
  output logic      [abfb_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  // command channel
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire logic [2:0]                    cmd,
  input  wire logic [abfb_pkg::COORD_W-1:0]  x,
  input  wire logic [abfb_pkg::COORD_W-1:0]  y,
  input  wire logic [abfb_pkg::COORD_W-1:0]  x2,
  input  wire logic [abfb_pkg::COORD_W-1:0]  y2,
  input  wire logic [abfb_pkg::CHAN_W-1:0]   red,
  input  wire logic [abfb_pkg::CHAN_W-1:0]   green,
  input  wire logic [abfb_pkg::CHAN_W-1:0]   blue,
  input  wire logic [abfb_pkg::INTEN_W-1:0]  intensity,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic      [abfb_pkg::CHAN_W-1:0]   read_red,
  output logic      [abfb_pkg::CHAN_W-1:0]   read_green,
  output logic      [abfb_pkg::CHAN_W-1:0]   read_blue,
  output logic                               status
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CW = abfb_pkg::COORD_W;
  localparam int OW = abfb_pkg::OPND_W;

  // configuration registers
  logic [CW-1:0] panel_width;
  logic [CW-1:0] panel_height;
  logic [CW-1:0] eff_w;
  logic [CW-1:0] eff_h;

  // control
  abfb_pkg::state_t state, state_next;
  logic [AW-1:0] clear_addr;
  logic          run_ready;
  logic          cmd_accept;
  logic          fill_step;

  // write port
  logic                 we;
  logic [AW-1:0]        wa;
  abfb_pkg::pixel_t     wd;

  // memory and read side
  abfb_pkg::pixel_t     mem [DEPTH];
  abfb_pkg::pixel_t     rd_data;
  logic                 fwd_hit;
  abfb_pkg::pixel_t     fwd_data;

  // decode of the incoming item
  logic [CW:0]   ax;
  logic [CW:0]   ay;
  logic [AW-1:0] rd_addr;
  logic          in_pan;
  logic          fill_bad;
  logic          fill_empty;
  logic          fill_start;
  logic          a_we;
  logic          a_add;
  logic          a_rd;
  logic          a_status;
  logic [OW-1:0] a_op_r;
  logic [OW-1:0] a_op_g;
  logic [OW-1:0] a_op_b;

  // modify stage
  logic          b_valid;
  logic          b_we;
  logic          b_add;
  logic          b_rd;
  logic          b_status;
  logic [AW-1:0] b_addr;
  logic [OW-1:0] b_op_r;
  logic [OW-1:0] b_op_g;
  logic [OW-1:0] b_op_b;
  logic          b_adv;
  abfb_pkg::pixel_t b_pix;
  abfb_pkg::pixel_t b_new;

  // fill walker
  logic [CW-1:0] fill_column;
  logic [CW-1:0] fill_row;
  logic [CW-1:0] fill_top;
  logic [CW-1:0] fill_right;
  logic [CW-1:0] fill_bottom;
  abfb_pkg::pixel_t fill_color;
  logic          fill_row_last;
  logic          fill_last;
  logic [AW-1:0] fill_addr;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= abfb_pkg::PANEL_RESET;
      panel_height <= abfb_pkg::PANEL_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        abfb_pkg::REG_PANEL_WIDTH:  panel_width  <= pwdata[CW-1:0];
        abfb_pkg::REG_PANEL_HEIGHT: panel_height <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      abfb_pkg::REG_PANEL_WIDTH:  prdata = abfb_pkg::PDATA_W'(panel_width);
      abfb_pkg::REG_PANEL_HEIGHT: prdata = abfb_pkg::PDATA_W'(panel_height);
      default:                    prdata = '0;
    endcase
  end

  // panel size clipped to the store
  assign eff_w = (11'(panel_width) < 11'(MAX_WIDTH)) ? panel_width : CW'(MAX_WIDTH);
  assign eff_h = (11'(panel_height) < 11'(MAX_HEIGHT)) ? panel_height : CW'(MAX_HEIGHT);

  // item decode: target pixel, bounds, operands
  assign ax = (cmd == abfb_pkg::CMD_BLEND) ? ({1'b0, x} + {1'b0, x2}) : {1'b0, x};
  assign ay = (cmd == abfb_pkg::CMD_BLEND) ? ({1'b0, y} + {1'b0, y2}) : {1'b0, y};
  assign in_pan  = (ax < {1'b0, eff_w}) && (ay < {1'b0, eff_h});
  assign rd_addr = {YW'(ay), XW'(ax)};

  assign fill_bad   = (x > x2) || (y > y2) || (x2 > eff_w) || (y2 > eff_h);
  assign fill_empty = (x == x2) || (y == y2);
  assign fill_start = (cmd == abfb_pkg::CMD_FILL) && !fill_bad && !fill_empty;

  always_comb begin
    a_we     = 1'b0;
    a_add    = 1'b0;
    a_rd     = 1'b0;
    a_status = 1'b0;
    a_op_r   = OW'(red);
    a_op_g   = OW'(green);
    a_op_b   = OW'(blue);
    case (cmd)
      abfb_pkg::CMD_SET: begin
        a_we     = in_pan;
        a_status = !in_pan;
      end
      abfb_pkg::CMD_ADD: begin
        a_we     = in_pan;
        a_add    = 1'b1;
        a_status = !in_pan;
      end
      abfb_pkg::CMD_BLEND: begin
        // clipped blend is silent
        a_we   = in_pan;
        a_add  = 1'b1;
        a_op_r = abfb_pkg::scale(red, intensity);
        a_op_g = abfb_pkg::scale(green, intensity);
        a_op_b = abfb_pkg::scale(blue, intensity);
      end
      abfb_pkg::CMD_FILL: begin
        a_status = fill_bad;
      end
      abfb_pkg::CMD_READ: begin
        a_rd     = in_pan;
        a_status = !in_pan;
      end
      default: begin
        a_status = 1'b1;
      end
    endcase
  end

  // handshake
  assign b_adv      = b_valid && (!result_valid || result_ready);
  assign run_ready  = !b_valid || b_adv;
  assign cmd_accept = cmd_valid && cmd_ready;

  // fill walker position
  assign fill_row_last = ({1'b0, fill_row} + 8'd1) == {1'b0, fill_bottom};
  assign fill_last     = fill_row_last &&
                         (({1'b0, fill_column} + 8'd1) == {1'b0, fill_right});
  assign fill_addr     = {YW'(fill_row), XW'(fill_column)};

  // control state machine and write port select
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abfb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    fill_step  = 1'b0;
    we         = 1'b0;
    wa         = b_addr;
    wd         = b_new;
    case (state)
      abfb_pkg::ST_CLEAR: begin
        we = 1'b1;
        wa = clear_addr;
        wd = '0;
        if (&clear_addr) state_next = abfb_pkg::ST_RUN;
      end
      abfb_pkg::ST_RUN: begin
        cmd_ready = run_ready;
        we        = b_adv && b_we;
        if (cmd_valid && run_ready && fill_start) state_next = abfb_pkg::ST_FILL;
      end
      abfb_pkg::ST_FILL: begin
        we        = 1'b1;
        wa        = fill_addr;
        wd        = fill_color;
        fill_step = 1'b1;
        if (fill_last) state_next = abfb_pkg::ST_RUN;
      end
      default: begin
        state_next = abfb_pkg::ST_CLEAR;
      end
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (state == abfb_pkg::ST_CLEAR) begin
      clear_addr <= clear_addr + AW'(1);
    end
  end

  // fill walker: columns outer, rows inner
  always_ff @(posedge clk) begin
    if (cmd_accept && fill_start) begin
      fill_column <= x;
      fill_row    <= y;
      fill_top    <= y;
      fill_right  <= x2;
      fill_bottom <= y2;
      fill_color  <= '{red: red, green: green, blue: blue};
    end else if (fill_step) begin
      if (fill_row_last) begin
        fill_row    <= fill_top;
        fill_column <= fill_column + CW'(1);
      end else begin
        fill_row <= fill_row + CW'(1);
      end
    end
  end

  // pixel store; a write at the read edge to the same entry is forwarded
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd_accept) begin
      rd_data  <= mem[rd_addr];
      fwd_hit  <= we && (wa == rd_addr);
      fwd_data <= wd;
    end
  end

  // modify stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (cmd_accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      b_we     <= a_we;
      b_add    <= a_add;
      b_rd     <= a_rd;
      b_status <= a_status;
      b_addr   <= rd_addr;
      b_op_r   <= a_op_r;
      b_op_g   <= a_op_g;
      b_op_b   <= a_op_b;
    end
  end

  // modify: overwrite or saturating add
  assign b_pix = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    if (b_add) begin
      b_new.red   = abfb_pkg::sat_add(b_pix.red, b_op_r);
      b_new.green = abfb_pkg::sat_add(b_pix.green, b_op_g);
      b_new.blue  = abfb_pkg::sat_add(b_pix.blue, b_op_b);
    end else begin
      b_new.red   = b_op_r[abfb_pkg::CHAN_W-1:0];
      b_new.green = b_op_g[abfb_pkg::CHAN_W-1:0];
      b_new.blue  = b_op_b[abfb_pkg::CHAN_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      read_red   <= b_rd ? b_pix.red   : '0;
      read_green <= b_rd ? b_pix.green : '0;
      read_blue  <= b_rd ? b_pix.blue  : '0;
      status     <= b_status;
    end
  end

  // checks
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == abfb_pkg::ST_CLEAR) |-> !cmd_ready)
    else $error("item taken during clearing pass");

  a_no_rmw_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == abfb_pkg::ST_FILL) |-> !(b_valid && b_we))
    else $error("pixel write pending during fill walk");

  a_fill_enters_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd_accept && fill_start) |=> (state == abfb_pkg::ST_FILL))
    else $error("fill did not start its walk");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (read_red == '0 && read_green == '0 && read_blue == '0))
    else $error("rejected item returned pixel data");

endmodule
`default_nettype wire

### tb/additive_blend_frame_buffer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// additive_blend_frame_buffer_unit_tb
// Self-checking bench for the additive blend frame buffer. A behavioral copy
// of the pixel store predicts every result as commands are accepted. Directed
// corner commands run first, then random command streams over several panel
// sizes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module additive_blend_frame_buffer_unit_tb;

  localparam int STORE_W     = abfb_pkg::MAX_WIDTH_DEF;
  localparam int STORE_H     = abfb_pkg::MAX_HEIGHT_DEF;
  localparam int COORD_W     = abfb_pkg::COORD_W;
  localparam int CHAN_W      = abfb_pkg::CHAN_W;
  localparam int INTEN_W     = abfb_pkg::INTEN_W;
  localparam int PADDR_W     = abfb_pkg::PADDR_W;
  localparam int PDATA_W     = abfb_pkg::PDATA_W;
  localparam int SEG_ITEMS   = 334;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [2:0]         op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col2;
    logic [COORD_W-1:0] row2;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [INTEN_W-1:0] gain;
  } cmd_item_t;

  typedef struct packed {
    abfb_pkg::pixel_t pix;
    logic             bad;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic                 cmd_valid = 1'b0;
  logic                 cmd_ready;
  logic [2:0]           cmd       = abfb_pkg::CMD_READ;
  logic [COORD_W-1:0]   x         = '0;
  logic [COORD_W-1:0]   y         = '0;
  logic [COORD_W-1:0]   x2        = '0;
  logic [COORD_W-1:0]   y2        = '0;
  logic [CHAN_W-1:0]    red       = '0;
  logic [CHAN_W-1:0]    green     = '0;
  logic [CHAN_W-1:0]    blue      = '0;
  logic [INTEN_W-1:0]   intensity = '0;

  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [CHAN_W-1:0]    read_red;
  logic [CHAN_W-1:0]    read_green;
  logic [CHAN_W-1:0]    read_blue;
  logic                 status;

  // behavioral copy of the block state
  abfb_pkg::pixel_t     frame_mem [STORE_W*STORE_H];
  logic [COORD_W-1:0]   width_reg  = abfb_pkg::PANEL_RESET;
  logic [COORD_W-1:0]   height_reg = abfb_pkg::PANEL_RESET;

  cmd_item_t            pending_cmds[$];
  pixel_result_t        expected_results[$];
  int                   issued_count  = 0;
  int                   taken_count   = 0;
  int                   error_count   = 0;
  int                   cycle_count   = 0;
  int                   send_idle_pct = 9;
  int                   recv_idle_pct = 82;

  additive_blend_frame_buffer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .x            (x),
    .y            (y),
    .x2           (x2),
    .y2           (y2),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .intensity    (intensity),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .read_red     (read_red),
    .read_green   (read_green),
    .read_blue    (read_blue),
    .status       (status)
  );

  // clock, 4 ns period
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int panel_cols();
    return (int'(width_reg) < STORE_W) ? int'(width_reg) : STORE_W;
  endfunction

  function automatic int panel_rows();
    return (int'(height_reg) < STORE_H) ? int'(height_reg) : STORE_H;
  endfunction

  // scale by Q2.8 gain (round half up), then saturating add onto stored channel
  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] stored,
                                                   input logic [CHAN_W-1:0] src,
                                                   input logic [INTEN_W-1:0] gain,
                                                   input bit scaled);
    int addend;
    int sum;
    addend = scaled ? ((int'(src) * int'(gain) + 128) >>> 8) : int'(src);
    sum    = int'(stored) + addend;
    return (sum > 255) ? 8'hFF : sum[7:0];
  endfunction

  // apply one command to the copy of the store and return its result
  function automatic pixel_result_t apply_command(input cmd_item_t c);
    pixel_result_t    res;
    int               w;
    int               h;
    int               tx;
    int               ty;
    int               idx;
    abfb_pkg::pixel_t old;
    w   = panel_cols();
    h   = panel_rows();
    res = '0;
    case (c.op)
      abfb_pkg::CMD_SET, abfb_pkg::CMD_ADD, abfb_pkg::CMD_READ: begin
        if (int'(c.col) < w && int'(c.row) < h) begin
          idx = int'(c.row) * STORE_W + int'(c.col);
          old = frame_mem[idx];
          if (c.op == abfb_pkg::CMD_SET) begin
            frame_mem[idx] = '{red: c.red, green: c.green, blue: c.blue};
          end else if (c.op == abfb_pkg::CMD_ADD) begin
            frame_mem[idx].red   = blend_chan(old.red, c.red, c.gain, 1'b0);
            frame_mem[idx].green = blend_chan(old.green, c.green, c.gain, 1'b0);
            frame_mem[idx].blue  = blend_chan(old.blue, c.blue, c.gain, 1'b0);
          end else begin
            res.pix = old;
          end
        end else begin
          res.bad = 1'b1;
        end
      end
      abfb_pkg::CMD_BLEND: begin
        // target outside the panel is skipped without an error
        tx = int'(c.col) + int'(c.col2);
        ty = int'(c.row) + int'(c.row2);
        if (tx < w && ty < h) begin
          idx = ty * STORE_W + tx;
          old = frame_mem[idx];
          frame_mem[idx].red   = blend_chan(old.red, c.red, c.gain, 1'b1);
          frame_mem[idx].green = blend_chan(old.green, c.green, c.gain, 1'b1);
          frame_mem[idx].blue  = blend_chan(old.blue, c.blue, c.gain, 1'b1);
        end
      end
      abfb_pkg::CMD_FILL: begin
        if (c.col > c.col2 || c.row > c.row2 || int'(c.col2) > w || int'(c.row2) > h) begin
          res.bad = 1'b1;
        end else begin
          for (int cc = int'(c.col); cc < int'(c.col2); cc++)
            for (int rr = int'(c.row); rr < int'(c.row2); rr++)
              frame_mem[rr * STORE_W + cc] = '{red: c.red, green: c.green, blue: c.blue};
        end
      end
      default: res.bad = 1'b1;
    endcase
    return res;
  endfunction

  // driver: command channel and result back-pressure, driven on falling edge
  always @(negedge clk) begin : drv_blk
    cmd_item_t nxt;
    result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (taken_count == issued_count) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt        = pending_cmds.pop_front();
        cmd        <= nxt.op;
        x          <= nxt.col;
        y          <= nxt.row;
        x2         <= nxt.col2;
        y2         <= nxt.row2;
        red        <= nxt.red;
        green      <= nxt.green;
        blue       <= nxt.blue;
        intensity  <= nxt.gain;
        cmd_valid  <= 1'b1;
        issued_count++;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict for the item taken at this edge
  always @(posedge clk) begin : mon_blk
    pixel_result_t want;
    cmd_item_t     seen;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        flag_error("result with no command outstanding");
      end else begin
        want = expected_results.pop_front();
        if (read_red !== want.pix.red)
          flag_error($sformatf("read_red got %0d want %0d", read_red, want.pix.red));
        if (read_green !== want.pix.green)
          flag_error($sformatf("read_green got %0d want %0d", read_green, want.pix.green));
        if (read_blue !== want.pix.blue)
          flag_error($sformatf("read_blue got %0d want %0d", read_blue, want.pix.blue));
        if (status !== want.bad)
          flag_error($sformatf("status got %0b want %0b", status, want.bad));
      end
    end
    if (!rst && cmd_valid && cmd_ready) begin
      seen = '{op: cmd, col: x, row: y, col2: x2, row2: y2,
               red: red, green: green, blue: blue, gain: intensity};
      expected_results.push_back(apply_command(seen));
      taken_count++;
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input int cx, input int cy,
                           input int cx2, input int cy2, input int r, input int g,
                           input int b, input int k);
    cmd_item_t c;
    c = '{op: op, col: cx[COORD_W-1:0], row: cy[COORD_W-1:0],
          col2: cx2[COORD_W-1:0], row2: cy2[COORD_W-1:0], red: r[CHAN_W-1:0],
          green: g[CHAN_W-1:0], blue: b[CHAN_W-1:0], gain: k[INTEN_W-1:0]};
    pending_cmds.push_back(c);
  endtask

  // mostly inside the panel, sometimes anywhere from 0 to 64
  function automatic int pick_coord(input int lim);
    if ($urandom_range(0, 99) < 88) return $urandom_range(0, lim - 1);
    return $urandom_range(0, 64);
  endfunction

  function automatic cmd_item_t random_cmd(input int w, input int h);
    cmd_item_t c;
    int        sel;
    int        tx;
    int        ty;
    int        lo;
    int        hi;
    sel    = $urandom_range(0, 99);
    c.red   = CHAN_W'($urandom_range(0, 255));
    c.green = CHAN_W'($urandom_range(0, 255));
    c.blue  = CHAN_W'($urandom_range(0, 255));
    c.gain  = INTEN_W'($urandom_range(0, 1023));
    c.col2  = COORD_W'($urandom_range(0, 64));
    c.row2  = COORD_W'($urandom_range(0, 64));
    c.col   = COORD_W'(pick_coord(w));
    c.row   = COORD_W'(pick_coord(h));
    if (sel < 20) begin
      c.op = abfb_pkg::CMD_SET;
    end else if (sel < 38) begin
      c.op = abfb_pkg::CMD_ADD;
    end else if (sel < 60) begin
      c.op = abfb_pkg::CMD_BLEND;
      if ($urandom_range(0, 99) < 80) begin
        tx     = $urandom_range(0, w - 1);
        ty     = $urandom_range(0, h - 1);
        c.col  = COORD_W'($urandom_range(0, tx));
        c.row  = COORD_W'($urandom_range(0, ty));
        c.col2 = COORD_W'(tx - int'(c.col));
        c.row2 = COORD_W'(ty - int'(c.row));
      end else begin
        c.col = COORD_W'($urandom_range(0, 64));
        c.row = COORD_W'($urandom_range(0, 64));
      end
    end else if (sel < 70) begin
      c.op = abfb_pkg::CMD_FILL;
      sel  = $urandom_range(0, 99);
      if (sel < 4) begin
        // whole panel
        c.col  = '0;
        c.row  = '0;
        c.col2 = COORD_W'(w);
        c.row2 = COORD_W'(h);
      end else if (sel < 85) begin
        lo     = $urandom_range(0, w);
        hi     = (lo + 8 < w) ? lo + 8 : w;
        c.col  = COORD_W'(lo);
        c.col2 = COORD_W'($urandom_range(lo, hi));
        lo     = $urandom_range(0, h);
        hi     = (lo + 8 < h) ? lo + 8 : h;
        c.row  = COORD_W'(lo);
        c.row2 = COORD_W'($urandom_range(lo, hi));
      end else begin
        c.col = COORD_W'($urandom_range(0, 64));
        c.row = COORD_W'($urandom_range(0, 64));
      end
    end else begin
      c.op = abfb_pkg::CMD_READ;
    end
    return c;
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || taken_count != issued_count ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write with setup and access phases; lands at the access-phase rising edge
  task automatic write_reg(input logic idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == abfb_pkg::REG_PANEL_WIDTH) width_reg = value[COORD_W-1:0];
    else height_reg = value[COORD_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    int seg_cols [6] = '{64, 1, 64, 1, 37, 64};
    int seg_rows [6] = '{64, 1, 1, 64, 21, 64};
    foreach (frame_mem[i]) frame_mem[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners on the full 64x64 panel
    queue_cmd(abfb_pkg::CMD_READ,  0,  0,  0,  0,   0,   0,   0,    0);  // cleared store
    queue_cmd(abfb_pkg::CMD_SET,  63, 63,  0,  0, 255, 255, 255,    0);
    queue_cmd(abfb_pkg::CMD_ADD,  63, 63,  0,  0,   1, 255,   1, 1023);  // saturates
    queue_cmd(abfb_pkg::CMD_READ, 63, 63,  0,  0,   0,   0,   0,    0);
    queue_cmd(abfb_pkg::CMD_SET,  64,  0,  0,  0,  17,  17,  17,    0);  // off panel
    queue_cmd(abfb_pkg::CMD_ADD,  64, 64,  0,  0,   9,   9,   9,    0);  // off panel
    queue_cmd(abfb_pkg::CMD_READ,  0, 64,  0,  0,   0,   0,   0,    0);  // off panel
    queue_cmd(abfb_pkg::CMD_SET,   0,  0,  0,  0,  10,  20,  30,    0);
    queue_cmd(abfb_pkg::CMD_ADD,   0,  0,  0,  0, 250,   0,   5,    0);
    queue_cmd(abfb_pkg::CMD_READ,  0,  0,  0,  0,   0,   0,   0,    0);
    queue_cmd(abfb_pkg::CMD_BLEND, 1,  2,  3,  4, 255, 128,   1, 1023);  // max gain
    queue_cmd(abfb_pkg::CMD_BLEND, 1,  2,  3,  4, 255, 255, 255,    0);  // zero gain
    queue_cmd(abfb_pkg::CMD_BLEND, 0,  0,  0,  0,   1,   3, 255,  128);  // half rounds up
    queue_cmd(abfb_pkg::CMD_READ,  4,  6,  0,  0,   0,   0,   0,    0);
    queue_cmd(abfb_pkg::CMD_BLEND, 40, 5, 30,  0,  99,  99,  99,  256);  // clipped target
    queue_cmd(abfb_pkg::CMD_BLEND, 64, 64, 64, 64, 99,  99,  99,  256);  // far off panel
    queue_cmd(abfb_pkg::CMD_FILL,  5,  0,  3,  4,   7,   7,   7,    0);  // left past right
    queue_cmd(abfb_pkg::CMD_FILL,  0,  9,  4,  2,   7,   7,   7,    0);  // top past bottom
    queue_cmd(abfb_pkg::CMD_FILL, 10, 10, 10, 20,   7,   7,   7,    0);  // empty area
    queue_cmd(abfb_pkg::CMD_FILL,  0,  0, 64, 64,  33,  66,  99,    0);  // whole panel
    queue_cmd(abfb_pkg::CMD_READ, 63, 63,  0,  0,   0,   0,   0,    0);
    queue_cmd(abfb_pkg::CMD_FILL,  2,  3,  5,  7, 128,   0, 200,    0);
    queue_cmd(abfb_pkg::CMD_READ,  4,  6,  0,  0,   0,   0,   0,    0);
    queue_cmd(abfb_pkg::CMD_READ,  5,  6,  0,  0,   0,   0,   0,    0);
    wait_idle();

    // random streams; each pause lets every result arrive before resizing
    for (int s = 0; s < 6; s++) begin
      write_reg(abfb_pkg::REG_PANEL_WIDTH, seg_cols[s]);
      write_reg(abfb_pkg::REG_PANEL_HEIGHT, seg_rows[s]);
      if (s < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 82;
      end else if (s < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (SEG_ITEMS) pending_cmds.push_back(random_cmd(seg_cols[s], seg_rows[s]));
      wait_idle();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/abfb_pkg.sv
hdl/additive_blend_frame_buffer_unit.sv
tb/additive_blend_frame_buffer_unit_tb.sv
